// ----- hw/rtl/ssc_pkg.sv -----
// Package for the six-step commutator: register indexes, fault codes and step tables.
// No dependencies.
package ssc_pkg;
   localparam logic [2:0] CFG_DIRECTION  = 3'd0;
   localparam logic [2:0] CFG_START_STEP = 3'd1;
   localparam logic [2:0] CFG_DIVISOR    = 3'd2;
   localparam logic [2:0] CFG_DEMAG      = 3'd3;
   localparam logic [2:0] CFG_OC_THRESH  = 3'd4;
   localparam logic [2:0] CFG_OC_LIMIT   = 3'd5;
   localparam logic [2:0] CFG_STALL      = 3'd6;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_STALL   = 2'd1;
   localparam logic [1:0] FAULT_OC      = 2'd2;
   localparam logic [1:0] FAULT_TIMEOUT = 2'd3;

   localparam logic [1:0] SLOT_NEUTRAL  = 2'd0;
   localparam logic [1:0] SLOT_FLOAT    = 2'd1;
   localparam logic [1:0] SLOT_CURRENT  = 2'd2;

   typedef struct packed {
      logic start;   // begin one request
      logic dly_go;  // start delay division
   } cmd_type;

   typedef struct packed {
      logic dly_busy;
      logic zc;      // last request found a zero crossing
   } status_type;

   function automatic logic [2:0] high_of(input logic [2:0] s);
      case (s)
         3'd0, 3'd1: high_of = 3'b001;
         3'd2, 3'd3: high_of = 3'b010;
         default:    high_of = 3'b100;
      endcase
   endfunction

   function automatic logic [2:0] low_of(input logic [2:0] s);
      case (s)
         3'd0, 3'd5: low_of = 3'b010;
         3'd1, 3'd2: low_of = 3'b100;
         default:    low_of = 3'b001;
      endcase
   endfunction

   function automatic logic [1:0] float_of(input logic [2:0] s);
      case (s)
         3'd0, 3'd3: float_of = 2'd2;
         3'd1, 3'd4: float_of = 2'd1;
         default:    float_of = 2'd0;
      endcase
   endfunction
endpackage

// ----- hw/rtl/ssc_if.sv -----
// Valid/ready channel interfaces for requests, responses and register writes.
// Uses ssc_pkg for nothing; request and response widths are parameters.
interface ssc_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, func, sample, input ready);
   modport sink   (input valid, func, sample, output ready);
endinterface

interface ssc_rsp_if #(parameter int TIMER_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [2:0]            step;
   logic [2:0]            high_side;
   logic [2:0]            low_side;
   logic [1:0]            next_channel;
   logic [1:0]            floating_phase;
   logic                  sampling_enabled;
   logic                  zero_cross;
   logic                  commutated;
   logic [TIMER_BITS-1:0] interval;
   logic [1:0]            fault;
   modport source (output valid, step, high_side, low_side, next_channel, floating_phase,
                   sampling_enabled, zero_cross, commutated, interval, fault, input ready);
   modport sink   (input valid, step, high_side, low_side, next_channel, floating_phase,
                   sampling_enabled, zero_cross, commutated, interval, fault, output ready);
endinterface

interface ssc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ssc_ctrl.sv -----
// Controller: sequences one request through the datapath and the delay divider.
// Depends on ssc_pkg.
module ssc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ssc_pkg::cmd_type    cmd,
   input  ssc_pkg::status_type status
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       started_ff, started_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign cmd.start  = req_valid && req_ready;
   assign cmd.dly_go = (state_ff == ST_DIV) && !started_ff && status.zc;

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      case (state_ff)
         ST_IDLE: begin
            started_in = 1'b0;
            if (cmd.start) state_in = ST_DIV;
         end
         ST_DIV: begin
            // skip the divider when no crossing; else wait for it
            if (!started_ff) begin
               if (status.zc) started_in = 1'b1;
               else state_in = ST_OUT;
            end else if (!status.dly_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end
endmodule

// ----- hw/rtl/ssc_div.sv -----
// Restoring divider: floor(oldest*16/divisor), saturated to the timer range.
// Depends on ssc_pkg for nothing beyond widths passed in.
module ssc_div #(parameter int TIMER_BITS = 16) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [TIMER_BITS-1:0] dividend,
   input  logic [7:0]            divisor,
   output logic                  busy,
   output logic [TIMER_BITS-1:0] quotient
);
   localparam int NB = TIMER_BITS + 4;
   localparam int CB = $clog2(NB + 1);

   logic [NB-1:0] num_ff, num_in, q_ff, q_in;
   logic [8:0]    rem_ff, rem_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [8:0]    trial;

   assign busy = busy_ff;
   // quotient bits above the timer range mean saturation; divisor 0 yields all ones
   assign quotient = (q_ff[NB-1:TIMER_BITS] != '0) ? '1 : q_ff[TIMER_BITS-1:0];

   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[7:0], num_ff[NB-1]};
      if (go) begin
         num_in  = {dividend, 4'b0};
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CB'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            q_in   = {q_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end
endmodule

// ----- hw/rtl/ssc_dp.sv -----
// Datapath: commutation state, sample slots, zero-crossing detection, faults.
// Depends on ssc_pkg and ssc_div.
module ssc_dp #(
   parameter int SAMPLE_BITS = 12,
   parameter int TIMER_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ssc_pkg::cmd_type       cmd,
   output ssc_pkg::status_type    status,
   input  logic                   req_func,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   cfg_we,
   input  logic [2:0]             cfg_index,
   input  logic [15:0]            cfg_data,
   output logic [2:0]             step,
   output logic [1:0]             slot,
   output logic                   pending,
   output logic                   zc_pulse,
   output logic                   com_pulse,
   output logic [TIMER_BITS-1:0]  interval,
   output logic [1:0]             fault
);
   localparam logic [TIMER_BITS-1:0] TMAX = '1;

   logic                   dir_ff;
   logic [7:0]             divq_ff;
   logic [11:0]            demag_thr_ff, oc_thr_ff;
   logic [3:0]             oc_lim_ff;
   logic [10:0]            stall_lim_ff;

   logic [2:0]             step_ff, step_in;
   logic                   demag_ff, demag_in;
   logic [15:0]            prev_ff, prev_in;
   logic [11:0]            neutral_ff, neutral_in;
   logic [1:0]             slot_ff, slot_in;
   logic [10:0]            stall_ff, stall_in;
   logic [TIMER_BITS-1:0]  icnt_ff, icnt_in;
   logic [TIMER_BITS-1:0]  hist_ff [3];
   logic [TIMER_BITS-1:0]  hist_in [3];
   logic [TIMER_BITS-1:0]  dly_ff, dly_in;
   logic                   pend_ff, pend_in;
   logic [3:0]             occ_ff, occ_in;
   logic [1:0]             fault_ff, fault_in;
   logic                   zc_ff, zc_in, com_ff, com_in, load_ff;
   logic                   div_busy;
   logic [TIMER_BITS-1:0]  div_q;
   logic [15:0]            ev;
   logic                   rising;

   ssc_div #(.TIMER_BITS(TIMER_BITS)) u_div (
      .clock(clock), .reset(reset), .go(cmd.dly_go), .dividend(hist_ff[0]),
      .divisor(divq_ff), .busy(div_busy), .quotient(div_q));

   assign status.dly_busy = div_busy;
   assign status.zc       = zc_ff;
   assign step      = step_ff;
   assign slot      = slot_ff;
   assign pending   = pend_ff;
   assign zc_pulse  = zc_ff;
   assign com_pulse = com_ff;
   assign interval  = hist_ff[2];
   assign fault     = fault_ff;
   assign ev        = 16'(req_sample);
   assign rising    = (step_ff[0] == dir_ff);

   always_comb begin
      step_in = step_ff; demag_in = demag_ff; prev_in = prev_ff;
      neutral_in = neutral_ff; slot_in = slot_ff; stall_in = stall_ff;
      icnt_in = icnt_ff; hist_in = hist_ff; dly_in = dly_ff; pend_in = pend_ff;
      occ_in = occ_ff; fault_in = fault_ff; zc_in = zc_ff; com_in = com_ff;
      if (cmd.start) begin
         zc_in = 1'b0;
         com_in = 1'b0;
         if (fault_ff == ssc_pkg::FAULT_NONE) begin
            if (req_func) begin
               if (icnt_ff == TMAX) begin
                  fault_in = ssc_pkg::FAULT_TIMEOUT;
               end else begin
                  icnt_in = icnt_ff + 1'b1;
                  if (pend_ff) begin
                     if (dly_ff == '0) begin
                        // advance the step and rearm sensing
                        if (dir_ff) step_in = (step_ff >= 3'd5) ? 3'd0 : step_ff + 3'd1;
                        else        step_in = (step_ff == 3'd0) ? 3'd5 : step_ff - 3'd1;
                        demag_in = 1'b0;
                        prev_in  = 16'hFFFF;
                        slot_in  = ssc_pkg::SLOT_NEUTRAL;
                        pend_in  = 1'b0;
                        com_in   = 1'b1;
                     end else begin
                        dly_in = dly_ff - 1'b1;
                     end
                  end
               end
            end else if (!pend_ff) begin
               if (stall_ff >= stall_lim_ff) begin
                  fault_in = ssc_pkg::FAULT_STALL;
               end else begin
                  stall_in = stall_ff + 11'd1;
                  case (slot_ff)
                     ssc_pkg::SLOT_NEUTRAL: begin
                        neutral_in = ev[11:0];
                        slot_in = ssc_pkg::SLOT_FLOAT;
                     end
                     ssc_pkg::SLOT_FLOAT: begin
                        if (rising) begin
                           if (!demag_ff) begin
                              if (ev > prev_ff) demag_in = 1'b1;
                           end else if (ev > 16'(neutral_ff)) zc_in = 1'b1;
                           prev_in = ev;
                        end else begin
                           if (!demag_ff) begin
                              if (ev > 16'(demag_thr_ff)) demag_in = 1'b1;
                           end else if (ev < 16'(neutral_ff)) zc_in = 1'b1;
                        end
                        if (zc_in) begin
                           stall_in = '0;
                           hist_in[0] = hist_ff[1];
                           hist_in[1] = hist_ff[2];
                           hist_in[2] = icnt_ff;
                           icnt_in = '0;
                           pend_in = 1'b1;
                        end
                        slot_in = ssc_pkg::SLOT_CURRENT;
                     end
                     default: begin
                        if (ev > 16'(oc_thr_ff)) begin
                           if (occ_ff != 4'hF) occ_in = occ_ff + 4'd1;
                           if (occ_in >= oc_lim_ff) fault_in = ssc_pkg::FAULT_OC;
                        end
                        slot_in = ssc_pkg::SLOT_NEUTRAL;
                     end
                  endcase
               end
            end
         end
      end
      // load the delay when the divider finishes
      if (load_ff && !div_busy) dly_in = div_q;
      if (cfg_we && cfg_index == ssc_pkg::CFG_START_STEP)
         step_in = (cfg_data[2:0] > 3'd5) ? 3'd0 : cfg_data[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b1; divq_ff <= 8'd64;
         demag_thr_ff <= 12'd350; oc_thr_ff <= 12'd102; oc_lim_ff <= 4'd10;
         stall_lim_ff <= 11'd1000;
         step_ff <= 3'd0; demag_ff <= 1'b0; prev_ff <= 16'hFFFF; neutral_ff <= '0;
         slot_ff <= '0; stall_ff <= '0; icnt_ff <= '0;
         hist_ff[0] <= '0; hist_ff[1] <= '0; hist_ff[2] <= '0;
         dly_ff <= '0; pend_ff <= 1'b0; occ_ff <= '0; fault_ff <= '0;
         zc_ff <= 1'b0; com_ff <= 1'b0; load_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            case (cfg_index)
               ssc_pkg::CFG_DIRECTION:  dir_ff <= cfg_data[0];
               ssc_pkg::CFG_DIVISOR:    divq_ff <= cfg_data[7:0];
               ssc_pkg::CFG_DEMAG:      demag_thr_ff <= cfg_data[11:0];
               ssc_pkg::CFG_OC_THRESH:  oc_thr_ff <= cfg_data[11:0];
               ssc_pkg::CFG_OC_LIMIT:   oc_lim_ff <= cfg_data[3:0];
               ssc_pkg::CFG_STALL:      stall_lim_ff <= cfg_data[10:0];
               default: ;
            endcase
         end
         step_ff <= step_in; demag_ff <= demag_in; prev_ff <= prev_in;
         neutral_ff <= neutral_in; slot_ff <= slot_in; stall_ff <= stall_in;
         icnt_ff <= icnt_in; hist_ff <= hist_in; dly_ff <= dly_in; pend_ff <= pend_in;
         occ_ff <= occ_in; fault_ff <= fault_in; zc_ff <= zc_in; com_ff <= com_in;
         if (cmd.dly_go) load_ff <= 1'b1;
         else if (!div_busy) load_ff <= 1'b0;
      end
   end
endmodule

// ----- hw/rtl/sensorless_six_step_commutator.sv -----
// Top level of the sensorless six-step commutator.
// Depends on ssc_pkg, ssc_if, ssc_ctrl, ssc_dp and ssc_div.
//
// Each request is an ADC result or a timer tick and yields one response carrying the
// gate pattern, sensing channel, pulses and fault. A request goes from acceptance
// through the controller states DIV and OUT to its response, except that one finding
// a zero crossing also runs, in DIV, the commutation delay (oldest interval * 16 /
// divisor) through a restoring divider at one quotient bit a cycle.
// One request is in flight at a time; the controller holds req_ready low until the
// response has been taken. Register writes are accepted in any cycle, and must only be
// issued while no request is in flight. A fault holds until reset and halts stepping.
module sensorless_six_step_commutator #(
   parameter int SAMPLE_BITS = 12,
   parameter int TIMER_BITS  = 16
) (
   input logic clock,
   input logic reset,
   ssc_req_if.sink   req,
   ssc_rsp_if.source rsp,
   ssc_csr_if.sink   csr
);
   ssc_pkg::cmd_type    cmd;
   ssc_pkg::status_type status;
   logic [2:0] step;
   logic [1:0] slot, fault;
   logic       pending, zc, com, ok;
   logic [TIMER_BITS-1:0] interval;

   assign csr.ready = 1'b1;

   ssc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd(cmd), .status(status));

   ssc_dp #(.SAMPLE_BITS(SAMPLE_BITS), .TIMER_BITS(TIMER_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_func(req.func), .req_sample(req.sample),
      .cfg_we(csr.valid), .cfg_index(csr.index), .cfg_data(csr.data),
      .step(step), .slot(slot), .pending(pending), .zc_pulse(zc), .com_pulse(com),
      .interval(interval), .fault(fault));

   // drop the gates while faulted
   assign ok                   = (fault == ssc_pkg::FAULT_NONE);
   assign rsp.step             = step;
   assign rsp.high_side        = ok ? ssc_pkg::high_of(step) : 3'b000;
   assign rsp.low_side         = ok ? ssc_pkg::low_of(step) : 3'b000;
   assign rsp.next_channel     = slot;
   assign rsp.floating_phase   = ssc_pkg::float_of(step);
   assign rsp.sampling_enabled = ok && !pending;
   assign rsp.zero_cross       = zc;
   assign rsp.commutated       = com;
   assign rsp.interval         = interval;
   assign rsp.fault            = fault;

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(zc && com))
      else $error("zero crossing and commutation in one response");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step <= 3'd5) else $error("step out of range");
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      ($past(fault) != ssc_pkg::FAULT_NONE && !$past(reset)) |-> $stable(fault))
      else $error("fault cleared without reset");
endmodule
